/* hw/rtl/sprite_transparency_rle_encoder_top_assert.svh */
// Assertion macros shared by the encoder top level
`ifndef SPRITE_TRANSPARENCY_RLE_ENCODER_TOP_ASSERT_SVH
`define SPRITE_TRANSPARENCY_RLE_ENCODER_TOP_ASSERT_SVH

// Same-cycle implication, held off while reset is asserted
`define STRE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("stre assertion failed");

// Next-cycle implication, held off while reset is asserted
`define STRE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("stre assertion failed");

`endif

/* hw/rtl/stre_pkg.sv */
// Types and constants of the transparent-run RLE sprite encoder
package stre_pkg;

    localparam int unsigned RUN_CAP     = 255;
    localparam int unsigned MAX_WRITES  = 3;
    localparam int unsigned Q_DEPTH     = 4;
    localparam int unsigned Q_PTR_BITS  = $clog2(Q_DEPTH);
    localparam int unsigned WR_IDX_BITS = $clog2(MAX_WRITES);

    typedef enum logic [1:0] {
        REQ_PIXEL     = 2'd0,
        REQ_ROW_END   = 2'd1,
        REQ_NEW_IMAGE = 2'd2,
        REQ_UNUSED    = 2'd3
    } t_req;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] colour;
    } t_in;

    typedef struct packed {
        logic [15:0] write_addr;
        logic [7:0]  write_byte;
        logic        overflow;
        logic        last;
    } t_out;

    // One byte write, before the last flag is known
    typedef struct packed {
        logic [15:0] addr;
        logic [7:0]  data;
        logic        ovf;
    } t_wr;

    // All writes caused by one input item
    typedef struct packed {
        logic [WR_IDX_BITS-1:0]      cnt;
        t_wr [MAX_WRITES-1:0]        w;
    } t_bundle;

endpackage

/* hw/rtl/stre_front.sv */
// Front end: accepts items, tracks run state and builds the write bundle per item
module stre_front import stre_pkg::*; #(
    parameter int unsigned ADDR_BITS = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_in     i_item,
    input  logic    i_q_full,
    output logic    o_q_push,
    output t_bundle o_q_bundle
);

    localparam logic [ADDR_BITS-1:0] ADDR_MAX = {ADDR_BITS{1'b1}};
    localparam logic [ADDR_BITS:0]   ADDR_END = {1'b1, {ADDR_BITS{1'b0}}};

    logic [7:0]           r_trans, n_trans;
    logic [7:0]           r_opaque, n_opaque;
    logic [7:0]           r_prev, n_prev;
    logic                 r_pending, n_pending;
    logic [ADDR_BITS-1:0] r_slot, n_slot;
    logic [ADDR_BITS:0]   r_next_addr, n_next_addr;
    logic                 r_ovf, n_ovf;

    logic                   accept;
    logic [ADDR_BITS+1:0]   take_sum [MAX_WRITES];
    logic                   take_ovf [MAX_WRITES];
    logic [ADDR_BITS-1:0]   take_addr [MAX_WRITES];
    logic [15:0]            take_addr16 [MAX_WRITES];
    logic [ADDR_BITS+15:0]  slot_ext;
    logic [15:0]            slot_addr16;

    logic                 cond, flush_w, counted, trans_w, colour_w, pix_opaque;
    logic [1:0]           n_takes;
    logic [ADDR_BITS+1:0] end_sum;
    t_bundle              bundle;

    assign accept = i_push && !i_q_full;

    // Candidate addresses for up to three consecutive takes this beat
    always_comb begin
        logic [ADDR_BITS+15:0] ext;
        for (int j = 0; j < MAX_WRITES; j++) begin
            take_sum[j]    = {1'b0, r_next_addr} + (ADDR_BITS+2)'(j);
            take_ovf[j]    = (take_sum[j][ADDR_BITS+1:ADDR_BITS] != 2'b00);
            take_addr[j]   = take_ovf[j] ? ADDR_MAX : take_sum[j][ADDR_BITS-1:0];
            ext            = {16'b0, take_addr[j]};
            take_addr16[j] = ext[15:0];
        end
    end

    assign slot_ext    = {16'b0, r_slot};
    assign slot_addr16 = slot_ext[15:0];

    assign pix_opaque = (i_item.colour != 8'd0);
    assign cond       = (r_prev == 8'd0) || !pix_opaque || (r_opaque == 8'(RUN_CAP));
    assign flush_w    = cond && r_pending;
    assign counted    = cond && !pix_opaque && (r_trans != 8'(RUN_CAP));
    assign trans_w    = cond && !counted;
    assign colour_w   = !counted && pix_opaque;

    always_comb begin
        logic [WR_IDX_BITS-1:0] k;
        logic [1:0]             ct;
        k           = '0;
        ct          = '0;
        bundle      = '0;
        n_trans     = r_trans;
        n_opaque    = r_opaque;
        n_prev      = r_prev;
        n_pending   = r_pending;
        n_slot      = r_slot;
        n_ovf       = r_ovf;
        n_takes     = 2'd0;
        case (t_req'(i_item.req_type))
            REQ_PIXEL: begin
                if (flush_w) begin
                    bundle.w[k] = '{addr: slot_addr16, data: r_opaque, ovf: r_ovf};
                    k = k + 1'b1;
                end
                if (trans_w) begin
                    bundle.w[k] = '{addr: take_addr16[0], data: r_trans,
                                    ovf: r_ovf | take_ovf[0]};
                    k = k + 1'b1;
                    ct = 2'd2;
                end
                if (colour_w) begin
                    bundle.w[k] = '{addr: take_addr16[ct], data: i_item.colour,
                                    ovf: r_ovf | take_ovf[ct]};
                    k = k + 1'b1;
                end
                n_takes = ct + {1'b0, colour_w};
                n_prev  = i_item.colour;
                if (counted)
                    n_trans = r_trans + 8'd1;
                else if (trans_w)
                    n_trans = pix_opaque ? 8'd0 : 8'd1;
                n_opaque  = cond ? {7'd0, pix_opaque} : r_opaque + 8'd1;
                n_pending = cond ? trans_w : r_pending;
                if (trans_w)
                    n_slot = take_addr[1];
            end
            REQ_ROW_END: begin
                if (r_pending) begin
                    bundle.w[k] = '{addr: slot_addr16, data: r_opaque, ovf: r_ovf};
                    k = k + 1'b1;
                end
                bundle.w[k] = '{addr: take_addr16[0], data: 8'd0, ovf: r_ovf | take_ovf[0]};
                k = k + 1'b1;
                bundle.w[k] = '{addr: take_addr16[1], data: 8'd0, ovf: r_ovf | take_ovf[1]};
                k = k + 1'b1;
                n_takes   = 2'd2;
                n_trans   = 8'd0;
                n_opaque  = 8'd0;
                n_prev    = 8'd0;
                n_pending = 1'b0;
                n_slot    = '0;
            end
            REQ_NEW_IMAGE: begin
                n_trans   = 8'd0;
                n_opaque  = 8'd0;
                n_prev    = 8'd0;
                n_pending = 1'b0;
                n_slot    = '0;
            end
            default: begin
            end
        endcase
        bundle.cnt = k;
        // sticky flag follows the last take of this beat
        if (n_takes != 2'd0)
            n_ovf = r_ovf | take_ovf[n_takes - 2'd1];
    end

    // Saturate the free pointer at the end of the address space; a new image resets it to zero
    assign end_sum = {1'b0, r_next_addr} + {{ADDR_BITS{1'b0}}, n_takes};
    always_comb begin
        if (t_req'(i_item.req_type) == REQ_NEW_IMAGE)
            n_next_addr = '0;
        else if (end_sum[ADDR_BITS+1:ADDR_BITS] != 2'b00)
            n_next_addr = ADDR_END;
        else
            n_next_addr = end_sum[ADDR_BITS:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trans     <= '0;
            r_opaque    <= '0;
            r_prev      <= '0;
            r_pending   <= 1'b0;
            r_slot      <= '0;
            r_next_addr <= '0;
            r_ovf       <= 1'b0;
        end else if (accept) begin
            r_trans     <= n_trans;
            r_opaque    <= n_opaque;
            r_prev      <= n_prev;
            r_pending   <= n_pending;
            r_slot      <= n_slot;
            r_next_addr <= n_next_addr;
            r_ovf       <= (t_req'(i_item.req_type) == REQ_NEW_IMAGE) ? 1'b0 : n_ovf;
        end
    end

    assign o_q_push   = accept && (bundle.cnt != '0);
    assign o_q_bundle = bundle;

endmodule

/* hw/rtl/stre_back.sv */
// Back end: bundle queue, one write per beat while results are popped, out of a registered result stage
module stre_back import stre_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_push,
    input  t_bundle i_q_bundle,
    output logic    o_q_full,
    input  logic    i_pop,
    output logic    o_empty,
    output t_out    o_result
);

    t_bundle                r_mem [Q_DEPTH];
    logic [Q_PTR_BITS-1:0]  r_wr_ptr, r_rd_ptr;
    logic [Q_PTR_BITS:0]    r_count;
    logic [WR_IDX_BITS-1:0] r_idx;
    logic                   r_out_valid;
    t_out                   r_out;

    t_bundle head;
    t_wr     head_wr;
    logic    q_nonempty, pop_acc, load, head_last, q_pop;

    assign head       = r_mem[r_rd_ptr];
    assign head_wr    = head.w[r_idx];
    assign q_nonempty = (r_count != '0);
    assign pop_acc    = i_pop && r_out_valid;
    assign load       = q_nonempty && (!r_out_valid || pop_acc);
    assign head_last  = (r_idx == head.cnt - 1'b1);
    assign q_pop      = load && head_last;

    always_ff @(posedge i_clk) begin
        if (i_q_push)
            r_mem[r_wr_ptr] <= i_q_bundle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_q_push)
                r_wr_ptr <= r_wr_ptr + 1'b1;
            if (q_pop)
                r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count <= r_count + {{Q_PTR_BITS{1'b0}}, i_q_push}
                               - {{Q_PTR_BITS{1'b0}}, q_pop};
            if (load)
                r_idx <= head_last ? '0 : r_idx + 1'b1;
            if (load)
                r_out_valid <= 1'b1;
            else if (pop_acc)
                r_out_valid <= 1'b0;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (load)
            r_out <= '{write_addr: head_wr.addr, write_byte: head_wr.data,
                       overflow: head_wr.ovf, last: head_last};
    end

    assign o_q_full = (r_count == (Q_PTR_BITS+1)'(Q_DEPTH));
    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

endmodule

/* hw/rtl/sprite_transparency_rle_encoder_top.sv */
// Accepted bundles are queued, then each write loads into the registered result stage.
// Throughput: one item per cycle while writes average at most one per item; the result
// port moves one write per cycle while popped; a 4-entry bundle queue absorbs items with 2 or 3.
// Reset: synchronous active-low i_rst_n clears run state, address, flag and queues.
// Top level of the transparent-run RLE sprite encoder
module sprite_transparency_rle_encoder_top import stre_pkg::*; #(
    parameter int unsigned ADDR_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic push,
    output logic full,
    input  t_in  i_item,
    output logic empty,
    input  logic pop,
    output t_out o_result
);

`include "sprite_transparency_rle_encoder_top_assert.svh"

    logic    q_push;
    logic    q_full;
    t_bundle q_bundle;

    stre_front #(
        .ADDR_BITS (ADDR_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (i_item),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_bundle (q_bundle)
    );

    stre_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_push   (q_push),
        .i_q_bundle (q_bundle),
        .o_q_full   (q_full),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_result   (o_result)
    );

    assign full = q_full;

    `STRE_ASSERT_SAME(a_no_push_when_full, i_clk, i_rst_n, q_push, !q_full)
    `STRE_ASSERT_SAME(a_bundle_nonempty, i_clk, i_rst_n, q_push,
        (q_bundle.cnt != '0) && (q_bundle.cnt <= WR_IDX_BITS'(MAX_WRITES)))
    `STRE_ASSERT_NEXT(a_rest_of_bundle_follows, i_clk, i_rst_n,
        pop && !empty && !o_result.last, !empty)

endmodule
